>>> rtl/quat_rate_integrate_normalize_assert.svh
// Assertion macros for the quaternion rate integrator.
// Depends on nothing; the including module supplies clk and rst_n.
`ifndef QUAT_RATE_INTEGRATE_NORMALIZE_ASSERT_SVH
`define QUAT_RATE_INTEGRATE_NORMALIZE_ASSERT_SVH
`ifndef ASSERT_OFF
// check a condition at every clock edge
`define QRIN_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// check that a condition holds in the cycle after a trigger
`define QRIN_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);
`else
`define QRIN_ASSERT(lbl, cond, msg)
`define QRIN_ASSERT_NEXT(lbl, trig, cond, msg)
`endif
`endif

>>> rtl/qrin_pkg.sv
// Shared types, command and status structs and helpers for the quaternion
// rate integrator. No dependencies.
`timescale 1ns / 1ps

package qrin_pkg;

    localparam int PROD_W = 66;

    typedef enum logic [2:0] {OPA_RATE, OPA_Q, OPA_NQ, OPA_R, OPA_M} opa_sel_t;
    typedef enum logic [2:0] {OPB_STEP, OPB_S, OPB_NQ, OPB_R, OPB_Y2, OPB_T} opb_sel_t;
    typedef enum logic [2:0] {
        ACT_NONE, ACT_SRATE, ACT_UPD, ACT_SQ, ACT_Y2, ACT_T, ACT_R, ACT_OUT
    } act_kind_t;

    typedef struct packed {
        act_kind_t  kind;
        logic       neg;
        logic       first;
        logic       last;
        logic [1:0] idx;
    } act_t;

    typedef struct packed {
        logic       mul_en;
        opa_sel_t   opa;
        logic [1:0] a_idx;
        opb_sel_t   opb;
        logic [1:0] b_idx;
        act_t       act;
        logic       cap;
        logic       zchk;
        logic       norm_load;
        logic       norm_shift;
        logic       r_init;
        logic       out_load;
    } qrin_cmd_t;

    typedef struct packed {
        logic nq_zero;
        logic norm_ok;
    } qrin_sts_t;

    // clamp a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        hi = 66'sh0_0000_0000_7FFF_FFFF;
        lo = -66'sh0_0000_0000_8000_0000;
        if (v > hi)
            return 32'sh7FFF_FFFF;
        else if (v < lo)
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

endpackage

>>> rtl/qrin_ctrl.sv
// Sequencer for the quaternion rate integrator: steps the shared multiplier
// through scaling, update, norm, Newton and output scaling. Uses qrin_pkg.
`timescale 1ns / 1ps

module qrin_ctrl
    import qrin_pkg::*;
#(
    parameter int NEWTON_STEPS = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  qrin_sts_t sts,
    output qrin_cmd_t cmd
);

    localparam int SW = $clog2(NEWTON_STEPS + 1);
    localparam logic [4:0] RUN_LAST = 5'd19;
    localparam logic [4:0] OUT_LAST = 5'd4;

    typedef enum logic [2:0] {S_IDLE, S_RUN, S_ZCHK, S_NORM, S_NEWT, S_OUT, S_DONE} state_t;

    state_t         state_reg;
    logic [4:0]     cnt_reg;
    logic [2:0]     phase_reg;
    logic [SW-1:0]  nstep_reg;
    logic           out_valid_reg;

    function automatic qrin_cmd_t mk(input opa_sel_t a, input logic [1:0] ai,
                                     input opb_sel_t b, input logic [1:0] bi,
                                     input act_kind_t k, input logic ng,
                                     input logic f, input logic l,
                                     input logic [1:0] ix);
        qrin_cmd_t c;
        c = '0;
        c.mul_en    = 1'b1;
        c.opa       = a;
        c.a_idx     = ai;
        c.opb       = b;
        c.b_idx     = bi;
        c.act.kind  = k;
        c.act.neg   = ng;
        c.act.first = f;
        c.act.last  = l;
        c.act.idx   = ix;
        return c;
    endfunction

    // multiply schedule; act field applies to the product of that step
    function automatic qrin_cmd_t run_tab(input logic [4:0] c);
        qrin_cmd_t r;
        r = '0;
        unique case (c)
            5'd0:  r = mk(OPA_RATE, 2'd0, OPB_STEP, 2'd0, ACT_SRATE, 1'b0, 1'b0, 1'b0, 2'd0);
            5'd1:  r = mk(OPA_RATE, 2'd1, OPB_STEP, 2'd0, ACT_SRATE, 1'b0, 1'b0, 1'b0, 2'd1);
            5'd2:  r = mk(OPA_RATE, 2'd2, OPB_STEP, 2'd0, ACT_SRATE, 1'b0, 1'b0, 1'b0, 2'd2);
            5'd3:  r = mk(OPA_Q, 2'd1, OPB_S, 2'd0, ACT_UPD, 1'b1, 1'b1, 1'b0, 2'd0);
            5'd4:  r = mk(OPA_Q, 2'd2, OPB_S, 2'd1, ACT_UPD, 1'b1, 1'b0, 1'b0, 2'd0);
            5'd5:  r = mk(OPA_Q, 2'd3, OPB_S, 2'd2, ACT_UPD, 1'b1, 1'b0, 1'b1, 2'd0);
            5'd6:  r = mk(OPA_Q, 2'd0, OPB_S, 2'd0, ACT_UPD, 1'b0, 1'b1, 1'b0, 2'd1);
            5'd7:  r = mk(OPA_Q, 2'd3, OPB_S, 2'd1, ACT_UPD, 1'b0, 1'b0, 1'b0, 2'd1);
            5'd8:  r = mk(OPA_Q, 2'd2, OPB_S, 2'd2, ACT_UPD, 1'b1, 1'b0, 1'b1, 2'd1);
            5'd9:  r = mk(OPA_Q, 2'd0, OPB_S, 2'd1, ACT_UPD, 1'b0, 1'b1, 1'b0, 2'd2);
            5'd10: r = mk(OPA_Q, 2'd1, OPB_S, 2'd2, ACT_UPD, 1'b0, 1'b0, 1'b0, 2'd2);
            5'd11: r = mk(OPA_Q, 2'd3, OPB_S, 2'd0, ACT_UPD, 1'b1, 1'b0, 1'b1, 2'd2);
            5'd12: r = mk(OPA_Q, 2'd0, OPB_S, 2'd2, ACT_UPD, 1'b0, 1'b1, 1'b0, 2'd3);
            5'd13: r = mk(OPA_Q, 2'd2, OPB_S, 2'd0, ACT_UPD, 1'b0, 1'b0, 1'b0, 2'd3);
            5'd14: r = mk(OPA_Q, 2'd1, OPB_S, 2'd1, ACT_UPD, 1'b1, 1'b0, 1'b1, 2'd3);
            5'd15: r = mk(OPA_NQ, 2'd0, OPB_NQ, 2'd0, ACT_SQ, 1'b0, 1'b1, 1'b0, 2'd0);
            5'd16: r = mk(OPA_NQ, 2'd1, OPB_NQ, 2'd1, ACT_SQ, 1'b0, 1'b0, 1'b0, 2'd1);
            5'd17: r = mk(OPA_NQ, 2'd2, OPB_NQ, 2'd2, ACT_SQ, 1'b0, 1'b0, 1'b0, 2'd2);
            5'd18: r = mk(OPA_NQ, 2'd3, OPB_NQ, 2'd3, ACT_SQ, 1'b0, 1'b0, 1'b1, 2'd3);
            default: r = '0;
        endcase
        return r;
    endfunction

    qrin_cmd_t mul_c;
    qrin_cmd_t act_c;

    // decode commands from state and step counters
    always_comb
    begin
        cmd   = '0;
        mul_c = run_tab(cnt_reg);
        act_c = run_tab(cnt_reg - 5'd1);
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.cap = in_valid;
            end
            S_RUN:
            begin
                if (cnt_reg < RUN_LAST)
                begin
                    cmd.mul_en = 1'b1;
                    cmd.opa    = mul_c.opa;
                    cmd.a_idx  = mul_c.a_idx;
                    cmd.opb    = mul_c.opb;
                    cmd.b_idx  = mul_c.b_idx;
                end
                if (cnt_reg != 5'd0)
                    cmd.act = act_c.act;
            end
            S_ZCHK:
            begin
                cmd.zchk      = 1'b1;
                cmd.norm_load = !sts.nq_zero;
            end
            S_NORM:
            begin
                cmd.r_init     = sts.norm_ok;
                cmd.norm_shift = !sts.norm_ok;
            end
            S_NEWT:
            begin
                unique case (phase_reg)
                    3'd0:
                    begin
                        cmd.mul_en = 1'b1;
                        cmd.opa    = OPA_R;
                        cmd.opb    = OPB_R;
                    end
                    3'd1: cmd.act.kind = ACT_Y2;
                    3'd2:
                    begin
                        cmd.mul_en = 1'b1;
                        cmd.opa    = OPA_M;
                        cmd.opb    = OPB_Y2;
                    end
                    3'd3: cmd.act.kind = ACT_T;
                    3'd4:
                    begin
                        cmd.mul_en = 1'b1;
                        cmd.opa    = OPA_R;
                        cmd.opb    = OPB_T;
                    end
                    3'd5: cmd.act.kind = ACT_R;
                    default: cmd.act.kind = ACT_NONE;
                endcase
            end
            S_OUT:
            begin
                if (cnt_reg < OUT_LAST)
                begin
                    cmd.mul_en = 1'b1;
                    cmd.opa    = OPA_NQ;
                    cmd.a_idx  = cnt_reg[1:0];
                    cmd.opb    = OPB_R;
                end
                if (cnt_reg != 5'd0)
                begin
                    cmd.act.kind = ACT_OUT;
                    cmd.act.idx  = cnt_reg[1:0] - 2'd1;
                end
            end
            S_DONE:
            begin
                cmd.out_load = !out_valid_reg || out_ready;
            end
            default: cmd = '0;
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // advance state, counters and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            phase_reg     <= '0;
            nstep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_RUN;
                    end
                end
                S_RUN:
                begin
                    if (cnt_reg == RUN_LAST)
                        state_reg <= S_ZCHK;
                    else
                        cnt_reg <= cnt_reg + 5'd1;
                end
                S_ZCHK:
                begin
                    state_reg <= sts.nq_zero ? S_DONE : S_NORM;
                end
                S_NORM:
                begin
                    if (sts.norm_ok)
                    begin
                        phase_reg <= '0;
                        nstep_reg <= '0;
                        state_reg <= S_NEWT;
                    end
                end
                S_NEWT:
                begin
                    if (phase_reg == 3'd5)
                    begin
                        phase_reg <= '0;
                        if (nstep_reg == SW'(NEWTON_STEPS - 1))
                        begin
                            cnt_reg   <= '0;
                            state_reg <= S_OUT;
                        end
                        else
                            nstep_reg <= nstep_reg + 1'b1;
                    end
                    else
                        phase_reg <= phase_reg + 3'd1;
                end
                S_OUT:
                begin
                    if (cnt_reg == OUT_LAST)
                        state_reg <= S_DONE;
                    else
                        cnt_reg <= cnt_reg + 5'd1;
                end
                S_DONE:
                begin
                    if (cmd.out_load)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

>>> rtl/qrin_dp.sv
// Datapath for the quaternion rate integrator: shared 33x33 multiplier,
// accumulators, normalize shifter, Newton registers and result words. Uses qrin_pkg.
`timescale 1ns / 1ps

module qrin_dp
    import qrin_pkg::*;
#(
    parameter int FRAC_BITS = 30
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  qrin_cmd_t          cmd,
    output qrin_sts_t          sts,
    input  logic signed [31:0] rate_x,
    input  logic signed [31:0] rate_y,
    input  logic signed [31:0] rate_z,
    input  logic        [31:0] step_scale,
    output logic signed [31:0] out_w,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z,
    output logic               zero_norm
);

    localparam int RS      = 32 - FRAC_BITS;
    localparam int HS      = FRAC_BITS - 1;
    localparam int SH_BASE = 61 - FRAC_BITS;
    localparam logic signed [PROD_W-1:0] RS_HALF = 66'sd1 <<< (RS - 1);
    localparam logic signed [PROD_W-1:0] HS_HALF = 66'sd1 <<< (HS - 1);
    localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;
    localparam logic [31:0] R_SEED  = 32'd9 << 27;
    localparam logic [35:0] THREE_Q = 36'd3 << 30;

    logic signed [31:0] rate_reg [3];
    logic        [31:0] step_reg;
    logic signed [31:0] s_reg [3];
    logic signed [31:0] q_reg [4];
    logic signed [31:0] nq_reg [4];
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] acc_reg;
    logic        [64:0] nacc_reg;
    logic        [63:0] nsh_reg;
    logic        [5:0]  e_reg;
    logic        [31:0] m_reg;
    logic        [31:0] r_reg;
    logic        [31:0] y2_reg;
    logic        [31:0] t_reg;
    logic               flag_reg;
    logic signed [31:0] ow_reg, ox_reg, oy_reg, oz_reg;
    logic               oz_flag_reg;

    logic signed [32:0] a_op, b_op;
    logic signed [PROD_W-1:0] quart, acc_n, upd_sum, srate_v, out_v, rnd;
    logic        [5:0]  sh;
    logic        [35:0] my2, m5;

    // select multiplier operands
    always_comb
    begin
        unique case (cmd.opa)
            OPA_RATE: a_op = (cmd.a_idx < 2'd3) ? 33'(rate_reg[cmd.a_idx]) : 33'sd0;
            OPA_Q:    a_op = 33'(q_reg[cmd.a_idx]);
            OPA_NQ:   a_op = 33'(nq_reg[cmd.a_idx]);
            OPA_R:    a_op = $signed({1'b0, r_reg});
            OPA_M:    a_op = $signed({1'b0, m_reg});
            default:  a_op = 33'sd0;
        endcase
        unique case (cmd.opb)
            OPB_STEP: b_op = $signed({1'b0, step_reg});
            OPB_S:    b_op = (cmd.b_idx < 2'd3) ? 33'(s_reg[cmd.b_idx]) : 33'sd0;
            OPB_NQ:   b_op = 33'(nq_reg[cmd.b_idx]);
            OPB_R:    b_op = $signed({1'b0, r_reg});
            OPB_Y2:   b_op = $signed({1'b0, y2_reg});
            OPB_T:    b_op = $signed({1'b0, t_reg});
            default:  b_op = 33'sd0;
        endcase
    end

    // per-product arithmetic on the registered product
    always_comb
    begin
        srate_v = (prod_reg + RS_HALF) >>> RS;
        quart   = prod_reg >>> 2;
        acc_n   = (cmd.act.first ? 66'sd0 : acc_reg) + (cmd.act.neg ? -quart : quart);
        upd_sum = PROD_W'(q_reg[cmd.act.idx]) + ((acc_n + HS_HALF) >>> HS);
        sh      = 6'(SH_BASE) - {1'b0, e_reg[5:1]};
        rnd     = $signed((66'd1 << sh) >> 1);
        out_v   = (prod_reg + rnd) >>> sh;
        my2     = prod_reg[65:30];
        // seed slope from the mantissa that is being loaded
        m5      = ({4'd0, nsh_reg[63:32]} + {2'd0, nsh_reg[63:32], 2'b00}) >> 5;
    end

    assign sts.nq_zero = (nq_reg[0] == '0) && (nq_reg[1] == '0) &&
                         (nq_reg[2] == '0) && (nq_reg[3] == '0);
    assign sts.norm_ok = |nsh_reg[63:62];

    // hold the stored orientation, identity at reset and after a zero norm
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg[0] <= ONE_Q;
            q_reg[1] <= '0;
            q_reg[2] <= '0;
            q_reg[3] <= '0;
        end
        else if (cmd.zchk && sts.nq_zero)
        begin
            q_reg[0] <= ONE_Q;
            q_reg[1] <= '0;
            q_reg[2] <= '0;
            q_reg[3] <= '0;
        end
        else if (cmd.act.kind == ACT_OUT)
            q_reg[cmd.act.idx] <= sat32(out_v);
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            rate_reg[0] <= rate_x;
            rate_reg[1] <= rate_y;
            rate_reg[2] <= rate_z;
            step_reg    <= step_scale;
        end
        if (cmd.mul_en)
            prod_reg <= a_op * b_op;
        unique case (cmd.act.kind)
            ACT_SRATE:
            begin
                if (cmd.act.idx < 2'd3)
                    s_reg[cmd.act.idx] <= sat32(srate_v);
            end
            ACT_UPD:
            begin
                acc_reg <= acc_n;
                if (cmd.act.last)
                    nq_reg[cmd.act.idx] <= sat32(upd_sum);
            end
            ACT_SQ:   nacc_reg <= (cmd.act.first ? 65'd0 : nacc_reg) + prod_reg[64:0];
            ACT_Y2:   y2_reg <= prod_reg[61:30];
            ACT_T:    t_reg  <= (my2 > THREE_Q) ? 32'd0 : 32'(THREE_Q - my2);
            ACT_R:    r_reg  <= prod_reg[62:31];
            default:  ;
        endcase
        if (cmd.zchk)
            flag_reg <= sts.nq_zero;
        // normalize so that bit 63 or 62 is set, by even counts
        if (cmd.norm_load)
        begin
            nsh_reg <= nacc_reg[64] ? {64{1'b1}} : nacc_reg[63:0];
            e_reg   <= '0;
        end
        else if (cmd.norm_shift)
        begin
            if (nsh_reg[63:56] == 8'd0)
            begin
                nsh_reg <= nsh_reg << 8;
                e_reg   <= e_reg + 6'd8;
            end
            else
            begin
                nsh_reg <= nsh_reg << 2;
                e_reg   <= e_reg + 6'd2;
            end
        end
        if (cmd.r_init)
        begin
            m_reg <= nsh_reg[63:32];
            r_reg <= R_SEED - m5[31:0];
        end
        if (cmd.out_load)
        begin
            ow_reg      <= q_reg[0];
            ox_reg      <= q_reg[1];
            oy_reg      <= q_reg[2];
            oz_reg      <= q_reg[3];
            oz_flag_reg <= flag_reg;
        end
    end

    assign out_w     = ow_reg;
    assign out_x     = ox_reg;
    assign out_y     = oy_reg;
    assign out_z     = oz_reg;
    assign zero_norm = oz_flag_reg;

endmodule

>>> rtl/quat_rate_integrate_normalize.sv
// Channel | signals                                  | handshake
// input   | rate_x rate_y rate_z step_scale           | in_valid / in_ready
// output  | out_w out_x out_y out_z zero_norm         | out_valid / out_ready
//
// One word runs from accept through 19 products, the zero check, the normalize
// shifter, NEWTON_STEPS Newton steps of three products each and four output
// scalings on the shared 33x33 multiplier; a zero norm goes from the zero check
// straight to the result. Reset leaves the orientation at identity.
// A finished word waits in the output register; the next word is taken meanwhile.
// Top level of the quaternion rate integrator; uses qrin_pkg, qrin_ctrl, qrin_dp.
`timescale 1ns / 1ps
`include "quat_rate_integrate_normalize_assert.svh"

module quat_rate_integrate_normalize
    import qrin_pkg::*;
#(
    parameter int FRAC_BITS    = 30,
    parameter int NEWTON_STEPS = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] rate_x,
    input  logic signed [31:0] rate_y,
    input  logic signed [31:0] rate_z,
    input  logic        [31:0] step_scale,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] out_w,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z,
    output logic               zero_norm
);

    qrin_cmd_t cmd;
    qrin_sts_t sts;

    qrin_ctrl #(.NEWTON_STEPS(NEWTON_STEPS)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    qrin_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .rate_x     (rate_x),
        .rate_y     (rate_y),
        .rate_z     (rate_z),
        .step_scale (step_scale),
        .out_w      (out_w),
        .out_x      (out_x),
        .out_y      (out_y),
        .out_z      (out_z),
        .zero_norm  (zero_norm)
    );

    // a new result never overwrites one still waiting
    `QRIN_ASSERT(a_no_overwrite, !cmd.out_load || !out_valid || out_ready, "result overwritten")
    // the block is busy right after taking a word
    `QRIN_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
    // a zero-norm result is the identity
    `QRIN_ASSERT(a_zero_ident, !(out_valid && zero_norm) || ((out_w == (32'sd1 <<< FRAC_BITS)) && (out_x == 32'sd0) && (out_y == 32'sd0) && (out_z == 32'sd0)), "zero norm not identity")

endmodule
